### sv/lpct_pkg.sv
// ----------------------------------------------------------------------------
// lpct_pkg
// Types and constants shared by the long period compare timer files.
// ----------------------------------------------------------------------------
package lpct_pkg;

    localparam int OP_W      = 2;
    localparam int CH_W      = 2;
    localparam int PERIOD_W  = 32;
    localparam int HALF_W    = 16;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 24;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_EVENT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

    localparam logic [HALF_W-1:0] STEP_MAX = 16'hFFFF;

    typedef struct packed {
        logic [HALF_W-1:0] reload_high;
        logic [HALF_W-1:0] reload_low;
        logic [HALF_W-1:0] remain_high;
        logic [HALF_W-1:0] remain_low;
        logic [HALF_W-1:0] compare_store;
    } lpct_entry_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel_out;
        logic              fired;
        logic [HALF_W-1:0] compare_value;
        logic              armed_out;
    } lpct_result_t;

endpackage

### sv/long_period_compare_timer_unit.sv
// ----------------------------------------------------------------------------
// long_period_compare_timer_unit
// Four-channel extended-range output compare with 32-bit periods.
// ----------------------------------------------------------------------------
// The input stream carries one word per item: s_tuser holds the operation
// (arm, compare match event, disarm) and s_tdata the channel and the period.
// Every accepted word produces exactly one result word on the m_ side with
// the channel, the fired flag, the new compare value and the armed mark.
// Channel state lives in a simple dual-port synchronous memory with a
// registered read; a word is read when accepted, modified in the modify stage
// and written back as it leaves that stage, and a bypass register covers
// back-to-back words on the same channel. A result word passes the modify
// stage and then the output register before it becomes valid, and one word
// can be accepted in every cycle while the receiver keeps up. The result sits
// in an output register; when the receiver stalls, the word being processed
// waits in the modify stage and the input stalls only once both stages are
// full. Reset disarms all channels and marks every memory entry as empty, so
// an entry reads as zero until its channel is first written. No clearing
// pass is needed, and the block accepts words in the first cycle after reset.
// ----------------------------------------------------------------------------
module long_period_compare_timer_unit #(
    parameter int CHANNELS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: channel[1:0], period_us[33:2], zero fill.
    input  logic [lpct_pkg::S_DATA_W-1:0] s_tdata,
    // Fields from bit 0: operation[1:0].
    input  logic [lpct_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: channel_out[1:0], fired[2], compare_value[18:3],
    // armed_out[19], zero fill.
    output logic [lpct_pkg::M_DATA_W-1:0] m_tdata
);
    import lpct_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    lpct_entry_t          mem [CHANNELS];
    lpct_entry_t          rd_data_reg;
    logic [CHANNELS-1:0]  entry_valid_reg;
    logic [CHANNELS-1:0]  armed_reg;

    logic                 s1_valid_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [CH_W-1:0]      s1_ch_reg;
    logic [PERIOD_W-1:0]  s1_period_reg;
    logic                 fwd_hit_reg;
    lpct_entry_t          fwd_data_reg;

    logic                 m_valid_reg;
    lpct_result_t         m_result_reg;

    logic                 s_accept;
    logic                 s1_adv;
    logic [CH_W-1:0]      s_ch;
    logic [ADDR_W-1:0]    s_addr;
    logic [ADDR_W-1:0]    s1_addr;
    logic                 s1_in_range;
    lpct_entry_t          cur;
    lpct_entry_t          upd;
    logic                 cur_armed;
    logic                 armed_next;
    logic                 fired;
    lpct_result_t         result;

    assign s_ch        = s_tdata[CH_W-1:0];
    assign s_addr      = s_ch[ADDR_W-1:0];
    assign s1_addr     = s1_ch_reg[ADDR_W-1:0];
    assign s1_in_range = ({1'b0, s1_ch_reg} < (CH_W+1)'(CHANNELS));

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // Current entry: bypass from the previous write, memory, or empty.
    always_comb begin
        if (fwd_hit_reg) begin
            cur = fwd_data_reg;
        end else if (entry_valid_reg[s1_addr]) begin
            cur = rd_data_reg;
        end else begin
            cur = '0;
        end
        cur_armed = armed_reg[s1_addr];
    end

    always_comb begin
        upd        = cur;
        armed_next = cur_armed;
        fired      = 1'b0;
        unique case (s1_op_reg)
            OP_ARM: begin
                if (s1_period_reg != '0) begin
                    armed_next      = 1'b1;
                    upd.reload_low  = s1_period_reg[HALF_W-1:0];
                    upd.reload_high = s1_period_reg[PERIOD_W-1:HALF_W];
                    upd.remain_low  = s1_period_reg[HALF_W-1:0];
                    upd.remain_high = s1_period_reg[PERIOD_W-1:HALF_W];
                    upd.compare_store = (s1_period_reg[PERIOD_W-1:HALF_W] != '0)
                                        ? STEP_MAX : s1_period_reg[HALF_W-1:0];
                end
            end
            OP_EVENT: begin
                if (cur_armed) begin
                    if (cur.remain_high == '0 && cur.remain_low == '0) begin
                        upd.remain_low  = cur.reload_low;
                        upd.remain_high = cur.reload_high;
                        fired           = 1'b1;
                    end
                    if (upd.remain_high != '0) begin
                        upd.compare_store = upd.compare_store + STEP_MAX;
                        upd.remain_high   = upd.remain_high - 1'b1;
                    end else if (upd.remain_low != '0) begin
                        upd.compare_store = upd.compare_store + upd.remain_low;
                        upd.remain_low    = '0;
                    end
                end
            end
            OP_DISARM: begin
                armed_next = 1'b0;
            end
            default: begin
            end
        endcase

        result.channel_out = s1_ch_reg;
        if (s1_in_range) begin
            result.fired         = fired;
            result.compare_value = upd.compare_store;
            result.armed_out     = armed_next;
        end else begin
            result.fired         = 1'b0;
            result.compare_value = '0;
            result.armed_out     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[s_addr];
        end
        if (s1_adv && s1_in_range) begin
            mem[s1_addr] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            armed_reg       <= '0;
            entry_valid_reg <= '0;
            fwd_hit_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_adv && s1_in_range && (s1_ch_reg == s_ch);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s1_adv && s1_in_range) begin
                armed_reg[s1_addr]       <= armed_next;
                entry_valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg     <= s_tuser;
            s1_ch_reg     <= s_ch;
            s1_period_reg <= s_tdata[CH_W+PERIOD_W-1:CH_W];
            fwd_data_reg  <= upd;
        end
        if (s1_adv) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-$bits(lpct_result_t)){1'b0}},
                       m_result_reg.armed_out, m_result_reg.compare_value,
                       m_result_reg.fired, m_result_reg.channel_out};

endmodule

### sv/lpct_checker.sv
// ----------------------------------------------------------------------------
// lpct_checker
// Port-level checks for the long period compare timer, bound to the top level.
// ----------------------------------------------------------------------------
module lpct_checker #(
    parameter int CHANNELS = 4
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lpct_pkg::M_DATA_W-1:0] m_tdata
);
    import lpct_pkg::*;

    logic ch_out_of_range;

    assign ch_out_of_range = ({1'b0, m_tdata[CH_W-1:0]} >= (CH_W+1)'(CHANNELS));

    // No result word may be offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result word stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input is open whenever the output register is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input refused while the output register was free");

    // A channel beyond the configured count reports an all-zero state.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ch_out_of_range |-> m_tdata[M_DATA_W-1:CH_W] == '0)
        else $error("unused channel reported state");

    // A period can only complete on a channel that stays armed.
    a_fired_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[19])
        else $error("fired reported on a disarmed channel");

endmodule

bind long_period_compare_timer_unit lpct_checker #(.CHANNELS(CHANNELS)) u_lpct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
